// File: hw/rtl/pdfesc_pkg.sv
package pdfesc_pkg;

  localparam int unsigned CNT_W = 18;
  localparam int unsigned CAP_W = 19;

  localparam logic [CNT_W-1:0] MAX_OUT_LEN = 18'd262143;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7e;

  typedef enum logic [1:0] {
    ESC_PLAIN,
    ESC_PAIR,
    ESC_OCTAL
  } esc_kind_t;

  // one escaped byte plus a flag for the final byte of its input
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_t;

endpackage

// File: hw/rtl/pdfesc_in_if.sv
interface pdfesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: hw/rtl/pdfesc_out_if.sv
interface pdfesc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [17:0] position;
  logic        stored;
  logic        run_last;
  logic        text_done;
  logic [17:0] needed_length;
  logic [17:0] terminator_index;
  logic        terminator_valid;

  modport source (output valid, output out_byte, output position, output stored,
                  output run_last, output text_done, output needed_length,
                  output terminator_index, output terminator_valid, input ready);
  modport sink   (input valid, input out_byte, input position, input stored,
                  input run_last, input text_done, input needed_length,
                  input terminator_index, input terminator_valid, output ready);
endinterface

// File: hw/rtl/pdfesc_cfg_if.sv
interface pdfesc_cfg_if;
  logic        valid;
  logic        ready;
  logic [18:0] out_capacity;

  modport source (output valid, output out_capacity, input ready);
  modport sink   (input valid, input out_capacity, output ready);
endinterface

// File: hw/rtl/pdfesc_encode.sv
module pdfesc_encode (
  input  logic [7:0]       text_byte,
  input  logic [1:0]       idx,
  output pdfesc_pkg::esc_t esc
);

  pdfesc_pkg::esc_kind_t kind;

  always_comb begin
    if (text_byte == pdfesc_pkg::CH_LPAREN || text_byte == pdfesc_pkg::CH_RPAREN ||
        text_byte == pdfesc_pkg::CH_BSLASH) begin
      kind = pdfesc_pkg::ESC_PAIR;
    end else if (text_byte >= pdfesc_pkg::PRINT_LO && text_byte <= pdfesc_pkg::PRINT_HI) begin
      kind = pdfesc_pkg::ESC_PLAIN;
    end else begin
      kind = pdfesc_pkg::ESC_OCTAL;
    end
  end

  always_comb begin
    esc.ch   = text_byte;
    esc.last = 1'b1;
    unique case (kind)
      pdfesc_pkg::ESC_PLAIN: begin
        esc.ch   = text_byte;
        esc.last = 1'b1;
      end
      pdfesc_pkg::ESC_PAIR: begin
        esc.ch   = (idx == 2'd0) ? pdfesc_pkg::CH_BSLASH : text_byte;
        esc.last = (idx == 2'd1);
      end
      pdfesc_pkg::ESC_OCTAL: begin
        // backslash then three octal digits, most significant first
        case (idx)
          2'd0:    esc.ch = pdfesc_pkg::CH_BSLASH;
          2'd1:    esc.ch = pdfesc_pkg::CH_ZERO | {6'd0, text_byte[7:6]};
          2'd2:    esc.ch = pdfesc_pkg::CH_ZERO | {5'd0, text_byte[5:3]};
          default: esc.ch = pdfesc_pkg::CH_ZERO | {5'd0, text_byte[2:0]};
        endcase
        esc.last = (idx == 2'd3);
      end
      default: begin
        esc.ch   = text_byte;
        esc.last = 1'b1;
      end
    endcase
  end

endmodule

// File: hw/rtl/pdf_literal_string_escaper_top.sv
// Input words wait in the hold register; escaped words leave from the output register.
// An input word escapes to 1, 2 or 4 output words (plain, backslash pair, octal escape);
// one escaped word per cycle leaves the single result register unless out_ch stalls it.
// A new input word is taken in the cycle its predecessor's last escaped word is made.
// Reset (synchronous, rst_n low) clears the count, capacity and hold/output valid flags.
module pdf_literal_string_escaper_top (
  input  logic               clk,
  input  logic               rst_n,
  pdfesc_in_if.sink          in_ch,
  pdfesc_cfg_if.sink         cfg_ch,
  pdfesc_out_if.source       out_ch
);

  logic                               hold_v_r;
  logic [7:0]                         hold_byte_r;
  logic                               hold_eot_r;
  logic [1:0]                         hold_idx_r;
  logic [pdfesc_pkg::CNT_W-1:0]       count_r;
  logic [pdfesc_pkg::CAP_W-1:0]       cap_r;

  logic                               out_v_r;
  logic [7:0]                         out_byte_r;
  logic [pdfesc_pkg::CNT_W-1:0]       out_pos_r;
  logic                               out_stored_r;
  logic                               out_run_last_r;
  logic                               out_done_r;
  logic [pdfesc_pkg::CNT_W-1:0]       out_len_r;
  logic [pdfesc_pkg::CNT_W-1:0]       out_term_r;
  logic                               out_term_v_r;

  pdfesc_pkg::esc_t                   esc;
  logic                               out_load;
  logic                               in_take;
  logic                               sat;
  logic                               fits;
  logic                               done;
  logic [pdfesc_pkg::CNT_W-1:0]       pos;
  logic [pdfesc_pkg::CNT_W-1:0]       count_nxt;
  logic [pdfesc_pkg::CAP_W-1:0]       cap_m1;
  logic [pdfesc_pkg::CNT_W-1:0]       term_nxt;

  pdfesc_encode u_encode (
    .text_byte (hold_byte_r),
    .idx       (hold_idx_r),
    .esc       (esc)
  );

  assign out_load     = hold_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !hold_v_r || (out_load && esc.last);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    sat       = (count_r == pdfesc_pkg::MAX_OUT_LEN);
    pos       = count_r;
    count_nxt = sat ? count_r : count_r + 1'b1;
    fits      = !sat && (({1'b0, count_r} + 1'b1) < cap_r);
    done      = esc.last && hold_eot_r;
    cap_m1    = cap_r - 1'b1;
    // needed length is the count after this word; the terminator clamps it to cap - 1
    if (cap_r == '0) begin
      term_nxt = '0;
    end else if ({1'b0, count_nxt} < cap_m1) begin
      term_nxt = count_nxt;
    end else begin
      term_nxt = cap_m1[pdfesc_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      hold_idx_r <= 2'd0;
      count_r  <= '0;
      cap_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.out_capacity;
      end

      if (in_take) begin
        hold_v_r   <= 1'b1;
        hold_idx_r <= 2'd0;
      end else if (out_load) begin
        hold_v_r   <= !esc.last;
        hold_idx_r <= hold_idx_r + 2'd1;
      end

      if (out_load) begin
        count_r <= done ? '0 : count_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte_r <= in_ch.text_byte;
      hold_eot_r  <= in_ch.end_of_text;
    end
    if (out_load) begin
      out_byte_r     <= esc.ch;
      out_pos_r      <= pos;
      out_stored_r   <= fits;
      out_run_last_r <= esc.last;
      out_done_r     <= done;
      out_len_r      <= done ? count_nxt : '0;
      out_term_r     <= (done && cap_r != '0) ? term_nxt : '0;
      out_term_v_r   <= done && (cap_r != '0);
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.out_byte         = out_byte_r;
  assign out_ch.position         = out_pos_r;
  assign out_ch.stored           = out_stored_r;
  assign out_ch.run_last         = out_run_last_r;
  assign out_ch.text_done        = out_done_r;
  assign out_ch.needed_length    = out_len_r;
  assign out_ch.terminator_index = out_term_r;
  assign out_ch.terminator_valid = out_term_v_r;

endmodule
